FILE: rtl/ctsd_pkg.sv
// Package with the constants, types and helper functions of the convex template support descriptor.
package ctsd_pkg;

    localparam int MaxDirs   = 32;
    localparam int DirBits   = 5;
    localparam int CoordBits = 16;

    localparam logic [1:0] KIND_ROW = 2'd0;
    localparam logic [1:0] KIND_INV = 2'd1;
    localparam logic [1:0] KIND_VTX = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         slot;
        logic signed [23:0] comp_x;
        logic signed [15:0] comp_y;
        logic signed [15:0] comp_z;
        logic               seg_end;
    } in_item_t;

    typedef struct packed {
        logic [4:0]         desc_index;
        logic signed [31:0] desc_value;
        logic               desc_last;
    } out_item_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic        load;       // capture the accepted item
        logic        vtx_clr;    // clear vertex accumulator
        logic        vtx_mac;    // accumulate one vertex product (component comp)
        logic        vtx_upd;    // saturate and update the maximum of row idx
        logic        t_clr;
        logic        t_mac;      // accumulate A[idx][comp] * d[idx] into t
        logic        t_fin;      // shift and saturate t[comp]
        logic        u_clr;
        logic        u_mac;      // accumulate Inv[idx3][comp] * t[comp]
        logic        u_fin;      // shift and saturate u[idx]
        logic        e_mac;      // accumulate A[idx][comp] * u[comp]
        logic        e_out;      // form the result of row idx into the output register
        logic        first;
        logic [1:0]  comp;
        logic [4:0]  idx;
        logic        last;
    } ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [37:0] sat38(input logic signed [63:0] v);
        if (v > 64'sh1f_ffff_ffff)
            return 38'sh1f_ffff_ffff;
        else if (v < -64'sh20_0000_0000)
            return 38'sh20_0000_0000;
        else
            return v[37:0];
    endfunction

endpackage

FILE: rtl/ctsd_stream_if.sv
// Valid-ready channel interface carrying one payload.
interface ctsd_stream_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ctsd_datapath.sv
// Datapath: template and inverse stores, support maxima, shared multiply-accumulate unit.
module ctsd_datapath (
    input  logic                clk,
    input  ctsd_pkg::ctrl_t     ctrl,
    input  ctsd_pkg::in_item_t  item,
    output ctsd_pkg::out_item_t res
);
    import ctsd_pkg::*;

    logic signed [15:0] rows_reg [MaxDirs][3];
    logic signed [23:0] inv_reg [9];
    logic signed [31:0] dmax_reg [MaxDirs];
    logic signed [37:0] t_reg [3];
    logic signed [37:0] u_reg [3];
    logic signed [63:0] acc_reg;
    in_item_t           it_reg;
    out_item_t          res_reg;

    logic signed [63:0] prod;
    logic signed [23:0] opa;
    logic signed [37:0] opb;
    logic signed [63:0] acc_sum;
    logic signed [37:0] vx;
    logic signed [37:0] vy;
    logic signed [37:0] vz;
    logic [3:0]         inv_idx;
    logic signed [31:0] dotv;

    assign vx = 38'(signed'(it_reg.comp_x[CoordBits-1:0]));
    assign vy = 38'(signed'(it_reg.comp_y[CoordBits-1:0]));
    assign vz = 38'(signed'(it_reg.comp_z[CoordBits-1:0]));
    assign inv_idx = 4'(ctrl.idx[1:0] * 3) + 4'(ctrl.comp);

    always_comb
    begin
        opa = 24'(rows_reg[ctrl.idx][ctrl.comp]);
        opb = 38'sd0;
        if (ctrl.vtx_mac)
        begin
            case (ctrl.comp)
                2'd0: opb = vx;
                2'd1: opb = vy;
                default: opb = vz;
            endcase
        end
        else if (ctrl.t_mac)
            opb = 38'(dmax_reg[ctrl.idx]);
        else if (ctrl.u_mac)
        begin
            opa = inv_reg[inv_idx];
            opb = t_reg[ctrl.comp];
        end
        else
            opb = u_reg[ctrl.comp];
        prod = 64'(opa) * 64'(opb);
        acc_sum = acc_reg + prod;
        dotv = sat32(acc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            it_reg <= item;
            if (item.kind == KIND_ROW)
            begin
                rows_reg[item.slot][0] <= item.comp_x[15:0];
                rows_reg[item.slot][1] <= item.comp_y;
                rows_reg[item.slot][2] <= item.comp_z;
            end
            if (item.kind == KIND_INV && item.slot < 5'd9)
                inv_reg[item.slot[3:0]] <= item.comp_x;
        end
        if (ctrl.vtx_clr || ctrl.t_clr || ctrl.u_clr)
            acc_reg <= 64'sd0;
        else if (ctrl.vtx_mac || ctrl.t_mac || ctrl.u_mac || ctrl.e_mac)
            acc_reg <= acc_sum;
        if (ctrl.vtx_upd)
        begin
            if (ctrl.first || dotv > dmax_reg[ctrl.idx])
                dmax_reg[ctrl.idx] <= dotv;
        end
        if (ctrl.t_fin)
            t_reg[ctrl.comp] <= sat38(acc_reg >>> 14);
        if (ctrl.u_fin)
            u_reg[ctrl.idx[1:0]] <= sat38(acc_reg >>> 16);
        if (ctrl.e_out)
        begin
            res_reg.desc_index <= ctrl.idx;
            res_reg.desc_value <= sat32(64'(dmax_reg[ctrl.idx]) - (acc_reg >>> 14));
            res_reg.desc_last  <= ctrl.last;
        end
    end

    assign res = res_reg;
endmodule

FILE: rtl/ctsd_ctrl.sv
// Controller state machine sequencing vertex updates and the descriptor pass.
module ctsd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ctsd_pkg::in_item_t  in_data,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic [5:0]          dirs_in_use,
    output ctsd_pkg::ctrl_t     ctrl
);
    import ctsd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_VMAC = 4'd1;
    localparam logic [3:0] S_VUPD = 4'd2;
    localparam logic [3:0] S_TMAC = 4'd3;
    localparam logic [3:0] S_TFIN = 4'd4;
    localparam logic [3:0] S_UMAC = 4'd5;
    localparam logic [3:0] S_UFIN = 4'd6;
    localparam logic [3:0] S_EMAC = 4'd7;
    localparam logic [3:0] S_EOUT = 4'd8;
    localparam logic [3:0] S_WAIT = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] comp_reg, comp_next;
    logic [4:0] idx_reg, idx_next;
    logic       first_reg, first_next;
    logic       end_reg, end_next;
    logic       ov_reg, ov_next;
    logic [4:0] nlast;
    logic       accept;

    always_comb
    begin
        if (dirs_in_use == 6'd0)
            nlast = 5'd0;
        else if (dirs_in_use > 6'(MaxDirs))
            nlast = 5'(MaxDirs - 1);
        else
            nlast = 5'(dirs_in_use - 6'd1);
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        end_next   = end_reg;
        ov_next    = ov_reg;
        ctrl = '0;
        ctrl.comp  = comp_reg;
        ctrl.idx   = idx_reg;
        ctrl.first = first_reg;
        ctrl.last  = (idx_reg == nlast);
        ctrl.load  = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.kind == KIND_VTX)
                begin
                    end_next   = in_data.seg_end;
                    idx_next   = '0;
                    comp_next  = '0;
                    ctrl.vtx_clr = 1'b1;
                    state_next = S_VMAC;
                end
            end
            S_VMAC:
            begin
                ctrl.vtx_mac = 1'b1;
                if (comp_reg == 2'd2)
                    state_next = S_VUPD;
                else
                    comp_next = comp_reg + 2'd1;
            end
            S_VUPD:
            begin
                ctrl.vtx_upd = 1'b1;
                ctrl.vtx_clr = 1'b1;
                comp_next = '0;
                if (idx_reg == 5'(MaxDirs - 1))
                begin
                    first_next = 1'b0;
                    idx_next   = '0;
                    ctrl.t_clr = 1'b1;
                    state_next = end_reg ? S_TMAC : S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 5'd1;
                    state_next = S_VMAC;
                end
            end
            S_TMAC:
            begin
                ctrl.t_mac = 1'b1;
                if (idx_reg == nlast)
                    state_next = S_TFIN;
                else
                    idx_next = idx_reg + 5'd1;
            end
            S_TFIN:
            begin
                ctrl.t_fin = 1'b1;
                ctrl.t_clr = 1'b1;
                idx_next = '0;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = '0;
                    state_next = S_UMAC;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_TMAC;
                end
            end
            S_UMAC:
            begin
                ctrl.u_mac = 1'b1;
                if (comp_reg == 2'd2)
                    state_next = S_UFIN;
                else
                    comp_next = comp_reg + 2'd1;
            end
            S_UFIN:
            begin
                ctrl.u_fin = 1'b1;
                ctrl.u_clr = 1'b1;
                comp_next = '0;
                if (idx_reg == 5'd2)
                begin
                    idx_next   = '0;
                    state_next = S_EMAC;
                end
                else
                begin
                    idx_next   = idx_reg + 5'd1;
                    state_next = S_UMAC;
                end
            end
            S_EMAC:
            begin
                ctrl.e_mac = 1'b1;
                if (comp_reg == 2'd2)
                    state_next = S_EOUT;
                else
                    comp_next = comp_reg + 2'd1;
            end
            S_EOUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ctrl.e_out = 1'b1;
                    ctrl.u_clr = 1'b1;
                    ov_next    = 1'b1;
                    comp_next  = '0;
                    if (idx_reg == nlast)
                    begin
                        first_next = 1'b1;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 5'd1;
                        state_next = S_EMAC;
                    end
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (ov_reg && out_ready && !ctrl.e_out)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            comp_reg  <= '0;
            idx_reg   <= '0;
            first_reg <= 1'b1;
            end_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            idx_reg   <= idx_next;
            first_reg <= first_next;
            end_reg   <= end_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

FILE: rtl/convex_template_support_descriptor_top.sv
// Top level: APB register, controller and datapath of the support descriptor block.
// Each vertex is reduced against all 32 directions through the single shared
// multiply-accumulate unit; no new item is accepted until that is done. A last vertex then
// emits the n descriptor transfers, one result register deep, stalling on out_ch.ready.
// Asynchronous active-low reset clears the control state, sets dirs_in_use to 32 and
// marks the next vertex as first; the support maxima reload from that first vertex.
module convex_template_support_descriptor_top (
    input  logic        clk,
    input  logic        rst_n,
    ctsd_stream_if.sink   in_ch,
    ctsd_stream_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ctsd_pkg::*;

    logic [5:0] dirs_reg;
    ctrl_t      ctrl;
    in_item_t   item;
    out_item_t  res;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {26'd0, dirs_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dirs_reg <= 6'd32;
        else if (psel && penable && pwrite && paddr == 2'd0)
            dirs_reg <= pwdata[5:0];
    end

    assign item = in_ch.data;

    ctsd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_data     (item),
        .in_ready    (in_ch.ready),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .dirs_in_use (dirs_reg),
        .ctrl        (ctrl)
    );

    ctsd_datapath u_dp (
        .clk  (clk),
        .ctrl (ctrl),
        .item (item),
        .res  (res)
    );

    assign out_ch.data = res;
endmodule
